// ===== hdl/pcm_hr_pkg.sv =====
// Package for the PCM hold rate converter: types, constants, sample decode.
`default_nettype none
package pcm_hr_pkg;

    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned PHASE_W    = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [PHASE_W-1:0] RATE_STEP_RESET = 32'h0001_0000;
    localparam logic [PHASE_W-1:0] PHASE_ONE       = 32'h0001_0000;
    localparam logic [7:0]         BYTE_BIAS       = 8'd128;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE_STEP    = 2'd0,
        CFG_MONO_MODE    = 2'd1,
        CFG_BYTE_SAMPLES = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [PHASE_W-1:0] rate_step;
        logic               mono_mode;
        logic               byte_samples;
    } t_cfg;

    typedef struct packed {
        logic [SAMPLE_W-1:0] frame_left;
        logic [SAMPLE_W-1:0] frame_right;
        logic                source_empty;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
        logic                       took_frame;
        logic                       silent;
    } t_out_item;

    function automatic logic [SAMPLE_W-1:0] decode_sample(
        input logic [SAMPLE_W-1:0] raw,
        input logic                byte_mode
    );
        logic [7:0] b;
        b = raw[7:0] - BYTE_BIAS;
        if (byte_mode) begin
            return {b, 8'h00};
        end
        return raw;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/pcm_hr_cfg_regs.sv =====
// Configuration register file of the PCM hold rate converter.
`default_nettype none
module pcm_hr_cfg_regs
    import pcm_hr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_RATE_STEP:    n_cfg.rate_step    = i_cfg_data;
                CFG_MONO_MODE:    n_cfg.mono_mode    = i_cfg_data[0];
                CFG_BYTE_SAMPLES: n_cfg.byte_samples = i_cfg_data[0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_step    <= RATE_STEP_RESET;
            r_cfg.mono_mode    <= 1'b0;
            r_cfg.byte_samples <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/pcm_hr_core.sv =====
// Phase accumulator, held pair and result register of the PCM hold rate converter.
`default_nettype none
module pcm_hr_core
    import pcm_hr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_data
);

    logic [PHASE_W-1:0]  r_phase_acc;
    logic [PHASE_W-1:0]  n_phase_acc;
    logic [SAMPLE_W-1:0] r_held_left;
    logic [SAMPLE_W-1:0] n_held_left;
    logic [SAMPLE_W-1:0] r_held_right;
    logic [SAMPLE_W-1:0] n_held_right;
    logic                r_out_valid;
    logic                n_out_valid;
    t_out_item           r_out_data;
    t_out_item           n_out_data;

    logic                accept;
    logic [PHASE_W-1:0]  phase_sum;
    logic                take;
    logic [SAMPLE_W-1:0] dec_left;
    logic [SAMPLE_W-1:0] dec_right;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign phase_sum = r_phase_acc + i_cfg.rate_step;
    assign take      = (phase_sum >= PHASE_ONE);
    assign dec_left  = decode_sample(i_in_data.frame_left, i_cfg.byte_samples);
    assign dec_right = i_cfg.mono_mode ? dec_left
                     : decode_sample(i_in_data.frame_right, i_cfg.byte_samples);

    always_comb begin
        n_phase_acc  = r_phase_acc;
        n_held_left  = r_held_left;
        n_held_right = r_held_right;
        n_out_data   = r_out_data;
        n_out_valid  = r_out_valid && !i_out_ready;
        if (accept) begin
            n_out_valid           = 1'b1;
            n_out_data.took_frame = 1'b0;
            n_out_data.silent     = 1'b0;
            if (i_in_data.source_empty) begin
                n_out_data.out_left  = '0;
                n_out_data.out_right = '0;
                n_out_data.silent    = 1'b1;
            end else if (take) begin
                n_phase_acc           = phase_sum - PHASE_ONE;
                n_held_left           = dec_left;
                n_held_right          = dec_right;
                n_out_data.out_left   = dec_left;
                n_out_data.out_right  = dec_right;
                n_out_data.took_frame = 1'b1;
            end else begin
                n_phase_acc          = phase_sum;
                n_out_data.out_left  = r_held_left;
                n_out_data.out_right = r_held_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc  <= '0;
            r_held_left  <= '0;
            r_held_right <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase_acc  <= n_phase_acc;
            r_held_left  <= n_held_left;
            r_held_right <= n_held_right;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

endmodule
`default_nettype wire

// ===== hdl/pcm_hold_rate_converter.sv =====
// Top level of the PCM zero-order-hold sample rate converter.
// Latency: a result is valid in the cycle after its input transfer.
// Throughput: one input item per cycle while results are taken; the result register frees as it is taken.
// Configuration writes are always ready.
// Reset (synchronous, active low) clears the phase, the held pair and the result valid,
// and loads the configuration registers with their reset values.
`default_nettype none
module pcm_hold_rate_converter
    import pcm_hr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data
);

    t_cfg cfg;

    pcm_hr_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pcm_hr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// ===== hdl/pcm_hr_checker.sv =====
// Port-level assertion checker of the PCM hold rate converter, with its bind.
`default_nettype none
module pcm_hr_checker
    import pcm_hr_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result changed while stalled");

    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.silent |->
            o_out_data.out_left == 16'sd0 && o_out_data.out_right == 16'sd0
            && !o_out_data.took_frame)
        else $error("silent result not zero");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind pcm_hold_rate_converter pcm_hr_checker u_pcm_hr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for pcm_hold_rate_converter: predicted ticks vs. DUT results.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pcm_hr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned STALL_CYCLES = 80;
    localparam int unsigned DRAIN_SLACK  = 2;
    localparam int unsigned BLOCK_ITEMS  = 24;

    class hold_tick_tracker;
        logic [PHASE_W-1:0]  rate_step;
        logic                mono_mode;
        logic                byte_samples;
        logic [PHASE_W-1:0]  phase;
        logic [SAMPLE_W-1:0] held_left;
        logic [SAMPLE_W-1:0] held_right;
        t_out_item           expected_ticks[$];
        int unsigned         mismatches;

        function new();
            rate_step    = RATE_STEP_RESET;
            mono_mode    = 1'b0;
            byte_samples = 1'b0;
            phase        = '0;
            held_left    = '0;
            held_right   = '0;
            mismatches   = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_RATE_STEP:    rate_step = data;
                CFG_MONO_MODE:    mono_mode = data[0];
                CFG_BYTE_SAMPLES: byte_samples = data[0];
                default: ;
            endcase
        endfunction

        function logic [SAMPLE_W-1:0] unpack_sample(logic [SAMPLE_W-1:0] raw);
            if (byte_samples) begin
                return {~raw[7], raw[6:0], 8'h00};
            end
            return raw;
        endfunction

        function void note_frame(t_in_item item);
            t_out_item          tick;
            logic [PHASE_W-1:0] sum;
            tick = '0;
            if (item.source_empty) begin
                tick.silent = 1'b1;
            end else begin
                sum = phase + rate_step;
                if (sum >= PHASE_ONE) begin
                    phase      = sum - PHASE_ONE;
                    held_left  = unpack_sample(item.frame_left);
                    held_right = mono_mode ? held_left : unpack_sample(item.frame_right);
                    tick.took_frame = 1'b1;
                end else begin
                    phase = sum;
                end
                tick.out_left  = held_left;
                tick.out_right = held_right;
            end
            expected_ticks.push_back(tick);
        endfunction

        function void compare_field(string field, logic [SAMPLE_W-1:0] want,
                                    logic [SAMPLE_W-1:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_tick(t_out_item got);
            t_out_item want;
            if (expected_ticks.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                mismatches++;
                return;
            end
            want = expected_ticks.pop_front();
            compare_field("out_left", want.out_left, got.out_left);
            compare_field("out_right", want.out_right, got.out_right);
            compare_field("took_frame", {15'd0, want.took_frame}, {15'd0, got.took_frame});
            compare_field("silent", {15'd0, want.silent}, {15'd0, got.silent});
        endfunction

        function int unsigned pending();
            return expected_ticks.size();
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_data   = '0;
    logic                  i_out_ready = 1'b0;
    logic                  o_cfg_ready;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_item             o_out_data;

    hold_tick_tracker board = new();
    int unsigned      send_idle_pct   = 15;
    int unsigned      recv_idle_pct   = 57;
    bit               stall_requested = 1'b0;
    int unsigned      stall_countdown = 0;
    int unsigned      cycle_count     = 0;

    pcm_hold_rate_converter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("pcm_hold_rate_converter verification failed");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_requested) begin
                stall_requested = 1'b0;
                stall_countdown = STALL_CYCLES;
            end
            if (stall_countdown > 0) begin
                stall_countdown--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_tick(o_out_data);
        end
    end

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic program_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        logic taken;
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end
        board.write_register(index, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic offer_frame(t_in_item item);
        logic taken;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_in_ready;
            @(posedge i_clk);
        end
        board.note_frame(item);
    endtask

    task automatic offer(logic [SAMPLE_W-1:0] left, logic [SAMPLE_W-1:0] right, logic empty);
        t_in_item item;
        item.frame_left   = left;
        item.frame_right  = right;
        item.source_empty = empty;
        offer_frame(item);
    endtask

    function automatic logic [PHASE_W-1:0] pick_rate_step();
        case ($urandom_range(7))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return PHASE_ONE;
            3: return $urandom_range(PHASE_ONE);
            4: return $urandom_range(32'h0004_0000, PHASE_ONE);
            5: return $urandom;
            6: return 32'h0000_8000;
            default: return 32'h0001_0001;
        endcase
    endfunction

    task automatic run_random_block(int unsigned count, bit pause_midway, bit hold_receiver);
        int unsigned tail_start;
        t_in_item    item;
        program_register(CFG_RATE_STEP, pick_rate_step());
        program_register(CFG_MONO_MODE, $urandom);
        program_register(CFG_BYTE_SAMPLES, $urandom);
        if (hold_receiver) begin
            stall_requested = 1'b1;
        end
        tail_start = $urandom_range(count, count / 2);
        for (int unsigned k = 0; k < count; k++) begin
            if (pause_midway && k == count / 2) begin
                wait_drained();
            end
            item.frame_left   = $urandom;
            item.frame_right  = $urandom;
            item.source_empty = (k >= tail_start) || ($urandom_range(99) < 4);
            offer_frame(item);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer(16'h0000, 16'h0000, 1'b0);
        offer(16'h7FFF, 16'h8000, 1'b0);
        offer(16'hFFFF, 16'h0001, 1'b0);
        offer(16'h8000, 16'h7FFF, 1'b0);
        offer(16'hFFFF, 16'hFFFF, 1'b1);
        offer(16'h1234, 16'h5678, 1'b0);
        program_register(CFG_RATE_STEP, 32'h0000_0000);
        offer(16'hAAAA, 16'h5555, 1'b0);
        offer(16'h0000, 16'h0000, 1'b1);
        offer(16'h5555, 16'hAAAA, 1'b0);
        program_register(CFG_RATE_STEP, PHASE_ONE);
        program_register(CFG_BYTE_SAMPLES, 32'h0000_0001);
        offer(16'h0000, 16'h00FF, 1'b0);
        offer(16'hFF80, 16'h007F, 1'b0);
        offer(16'h1201, 16'hAB7E, 1'b0);
        program_register(CFG_MONO_MODE, 32'hFFFF_FFFF);
        offer(16'h00FF, 16'h0000, 1'b0);
        offer(16'h8000, 16'h00FF, 1'b0);
        program_register(CFG_BYTE_SAMPLES, 32'hFFFF_FFFE);
        offer(16'h8000, 16'h1234, 1'b0);
        offer(16'h7FFF, 16'hFFFF, 1'b0);
        program_register(CFG_MONO_MODE, 32'h0000_0000);
        program_register(CFG_RATE_STEP, 32'hFFFF_FFFF);
        offer(16'h0101, 16'hFEFE, 1'b0);
        offer(16'h0202, 16'hFDFD, 1'b0);
        offer(16'h0303, 16'hFCFC, 1'b1);
        offer(16'h0404, 16'hFBFB, 1'b0);
        program_register(CFG_RATE_STEP, 32'h0000_8000);
        program_register(CFG_SPARE_INDEX, 32'hFFFF_FFFF);
        offer(16'hC001, 16'h3FFE, 1'b0);
        offer(16'hC002, 16'h3FFD, 1'b0);
        offer(16'hC003, 16'h3FFC, 1'b0);

        for (int unsigned b = 0; b < 21; b++) begin
            if (b == 7) begin
                send_idle_pct = 57;
                recv_idle_pct = 15;
            end else if (b == 14) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_random_block(BLOCK_ITEMS, b == 3 || b == 10, b == 15);
        end

        wait_drained();
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("pcm_hold_rate_converter verification clean");
        end else begin
            $display("pcm_hold_rate_converter verification failed");
        end
        $finish;
    end
endmodule
